// ===== src/cabo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cabo_pkg
// Shared types, constants and the coverage blend for the clipped alpha blit.
// ----------------------------------------------------------------------------
package cabo_pkg;

   // Default store geometry
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 64;

   // Field widths
   localparam int PIX_W       = 8;
   localparam int COORD_W     = 18;   // signed destination coordinate
   localparam int WIN_W_W     = 10;
   localparam int WIN_H_W     = 7;
   localparam int ORIGIN_W    = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PIX_W-1:0] ALPHA_MAX = 8'd255;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_X      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_Y      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_WIDTH  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_HEIGHT = 4'd3;

   localparam logic [WIN_W_W-1:0] WIN_WIDTH_RST  = 10'd512;
   localparam logic [WIN_H_W-1:0] WIN_HEIGHT_RST = 7'd64;

   typedef enum logic [1:0] {
      FUNC_BLEND = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   // Control that travels with a pixel from clipping to write-back
   typedef struct packed {
      logic             hit;
      func_type         func;
      logic [PIX_W-1:0] cov;
   } pix_ctl_type;

   // src + floor((255-src)*dst/255); the division by 255 uses
   // floor(p/255) = (p + (p>>8) + 1) >> 8, exact for p up to 255*255
   function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] src,
                                                   input logic [PIX_W-1:0] dst);
      logic [2*PIX_W-1:0] prod;
      logic [2*PIX_W:0]   acc;
      prod = {8'd0, ALPHA_MAX - src} * {8'd0, dst};
      acc  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
      return src + acc[15:8];
   endfunction

endpackage
`default_nettype wire

// ===== src/clipped_alpha_blit_over.sv =====
`default_nettype none
// A request word is held in the clip, read and output registers in turn.
// Throughput: one word per cycle unless rsp_stall or the clearing sweep
// holds it, set by one read-modify-write of the window memory per cycle,
// with the latest write forwarded to a following read. After reset the memory
// is cleared one pixel a cycle, all MAX_WIDTH*MAX_HEIGHT pixels (32768 by
// default), with req_stall held high; register writes are taken throughout.
// ----------------------------------------------------------------------------
// clipped_alpha_blit_over
// Composites glyph coverage into a stored alpha window: clip, address,
// read, blend and write back, plus pixel read-out and pixel clear.
// ----------------------------------------------------------------------------
module clipped_alpha_blit_over
   import cabo_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_func,
   input  wire logic signed [15:0]     req_pen_x,
   input  wire logic signed [15:0]     req_pen_y,
   input  wire logic signed [9:0]      req_bearing_x,
   input  wire logic signed [9:0]      req_bearing_y,
   input  wire logic [8:0]             req_col,
   input  wire logic [8:0]             req_row,
   input  wire logic [7:0]             req_coverage,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_pixel_value,
   output logic                        rsp_in_window,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Configuration registers
   logic signed [ORIGIN_W-1:0] win_x_ff, win_y_ff;
   logic [WIN_W_W-1:0]         win_width_ff;
   logic [WIN_H_W-1:0]         win_height_ff;
   logic [WIN_W_W-1:0]         eff_w;
   logic [WIN_H_W-1:0]         eff_h;

   // Pipeline control
   logic        take, out_free, s3_free, s3_adv, s1_adv;
   logic        s1_valid;
   pix_ctl_type s1_ctl;
   logic [AW-1:0] s1_addr;

   logic        s3_valid_ff, s3_valid_in;
   pix_ctl_type s3_ctl_ff;
   logic [AW-1:0] s3_addr_ff;

   logic [PIX_W-1:0] old_pix, new_pix, res_pix;
   logic             wr_en, clr_busy;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_value_ff;
   logic             rsp_in_window_ff;

   assign csr_ready = 1'b1;

   // Write configuration; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_ff      <= '0;
         win_y_ff      <= '0;
         win_width_ff  <= WIN_WIDTH_RST;
         win_height_ff <= WIN_HEIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIN_X:      win_x_ff      <= csr_wdata;
            CSR_WIN_Y:      win_y_ff      <= csr_wdata;
            CSR_WIN_WIDTH:  win_width_ff  <= csr_wdata[WIN_W_W-1:0];
            CSR_WIN_HEIGHT: win_height_ff <= csr_wdata[WIN_H_W-1:0];
            default: ;
         endcase
      end
   end

   // Limit the window to the store size
   always_comb begin
      eff_w = (32'(win_width_ff) > 32'(MAX_WIDTH)) ? WIN_W_W'(MAX_WIDTH) : win_width_ff;
      eff_h = (32'(win_height_ff) > 32'(MAX_HEIGHT)) ? WIN_H_W'(MAX_HEIGHT) : win_height_ff;
   end

   // Handshake and stage advance
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s3_adv    = s3_valid_ff && out_free;
      s3_free   = !s3_valid_ff || out_free;
      s1_adv    = s1_valid && s3_free;
      req_stall = clr_busy || (s1_valid && !s3_free);
      take      = req_valid && !req_stall;
   end

   cabo_clip #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .AW         (AW)
   ) u_clip (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .hand_on   (s1_adv),
      .func      (req_func),
      .pen_x     (req_pen_x),
      .pen_y     (req_pen_y),
      .bearing_x (req_bearing_x),
      .bearing_y (req_bearing_y),
      .col       (req_col),
      .row       (req_row),
      .coverage  (req_coverage),
      .win_x     (win_x_ff),
      .win_y     (win_y_ff),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .valid     (s1_valid),
      .ctl       (s1_ctl),
      .addr      (s1_addr)
   );

   cabo_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (s1_adv && s1_ctl.hit),
      .rd_addr (s1_addr),
      .wr_en   (wr_en),
      .wr_addr (s3_addr_ff),
      .wr_data (new_pix),
      .rd_data (old_pix),
      .busy    (clr_busy)
   );

   // Advance the read stage
   always_comb begin
      s3_valid_in = s3_valid_ff;
      if (s1_adv) begin
         s3_valid_in = 1'b1;
      end else if (s3_adv) begin
         s3_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s3_ctl_ff  <= s1_ctl;
         s3_addr_ff <= s1_addr;
      end
   end

   // Blend and write back
   always_comb begin
      case (s3_ctl_ff.func)
         FUNC_BLEND: new_pix = blend_over(s3_ctl_ff.cov, old_pix);
         FUNC_READ:  new_pix = old_pix;
         FUNC_CLEAR: new_pix = '0;
         default:    new_pix = '0;
      endcase
      res_pix = s3_ctl_ff.hit ? new_pix : '0;
      wr_en   = s3_adv && s3_ctl_ff.hit
                && (s3_ctl_ff.func == FUNC_BLEND || s3_ctl_ff.func == FUNC_CLEAR);
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s3_adv) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         rsp_pixel_value_ff <= res_pix;
         rsp_in_window_ff   <= s3_ctl_ff.hit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_value_ff;
   assign rsp_in_window   = rsp_in_window_ff;

endmodule
`default_nettype wire

// ===== src/cabo_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cabo_store
// Alpha window memory: one read and one write port, registered read data,
// write-to-read forwarding and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module cabo_store
   import cabo_pkg::*;
#(
   parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
   parameter int AW    = 15
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [PIX_W-1:0] wr_data,
   output logic      [PIX_W-1:0] rd_data,
   output logic                  busy
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] mem_q_ff;
   logic [AW-1:0]    rd_addr_ff;

   logic             clr_busy_ff, clr_busy_in;
   logic [AW-1:0]    clr_idx_ff, clr_idx_in;

   logic             byp_valid_ff;
   logic [AW-1:0]    byp_addr_ff;
   logic [PIX_W-1:0] byp_data_ff;

   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [PIX_W-1:0] mem_wd;

   // Select the write source: sweep first, pixel write-back otherwise
   always_comb begin
      mem_we = clr_busy_ff | wr_en;
      mem_wa = clr_busy_ff ? clr_idx_ff : wr_addr;
      mem_wd = clr_busy_ff ? '0 : wr_data;
   end

   // Advance the clearing sweep, one entry a cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
         if (mem_we) begin
            byp_valid_ff <= 1'b1;
         end
      end
   end

   // Remember the latest write for a read that raced it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byp_addr_ff <= mem_wa;
         byp_data_ff <= mem_wd;
      end
   end

   // Memory array, read-first
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff   <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   assign rd_data = (byp_valid_ff && byp_addr_ff == rd_addr_ff) ? byp_data_ff : mem_q_ff;
   assign busy    = clr_busy_ff;

endmodule
`default_nettype wire

// ===== src/cabo_clip.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cabo_clip
// Destination coordinate, window clipping and store address for one word.
// ----------------------------------------------------------------------------
module cabo_clip
   import cabo_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int AW         = 15
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       take,
   input  wire logic                       hand_on,
   input  wire logic [1:0]                 func,
   input  wire logic signed [15:0]         pen_x,
   input  wire logic signed [15:0]         pen_y,
   input  wire logic signed [9:0]          bearing_x,
   input  wire logic signed [9:0]          bearing_y,
   input  wire logic [8:0]                 col,
   input  wire logic [8:0]                 row,
   input  wire logic [PIX_W-1:0]           coverage,
   input  wire logic signed [ORIGIN_W-1:0] win_x,
   input  wire logic signed [ORIGIN_W-1:0] win_y,
   input  wire logic [WIN_W_W-1:0]         eff_w,
   input  wire logic [WIN_H_W-1:0]         eff_h,
   output logic                            valid,
   output pix_ctl_type                     ctl,
   output logic [AW-1:0]                   addr
);

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LW = (YW + WIN_W_W + 1 > AW) ? YW + WIN_W_W + 1 : AW;

   logic                      s1_valid_ff, s1_valid_in;
   logic [1:0]                s1_func_ff;
   logic [PIX_W-1:0]          s1_cov_ff;
   logic signed [COORD_W-1:0] s1_sx_ff, s1_sy_ff;
   logic signed [COORD_W-1:0] sx_in, sy_in;

   logic                      in_x, in_y;
   logic [XW-1:0]             x;
   logic [YW-1:0]             y;
   logic [LW-1:0]             lin;

   // Form the coordinate: placed glyph pixel for blend, window pixel otherwise
   always_comb begin
      if (func == FUNC_BLEND) begin
         sx_in = COORD_W'(pen_x) + COORD_W'(bearing_x)
               + $signed({{(COORD_W-9){1'b0}}, col}) - COORD_W'(win_x);
         sy_in = COORD_W'(pen_y) + COORD_W'(bearing_y)
               + $signed({{(COORD_W-9){1'b0}}, row}) - COORD_W'(win_y);
      end else begin
         sx_in = $signed({{(COORD_W-9){1'b0}}, col});
         sy_in = $signed({{(COORD_W-9){1'b0}}, row});
      end
   end

   // Hold the word until the next stage takes it
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (hand_on) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_func_ff <= func;
         s1_cov_ff  <= coverage;
         s1_sx_ff   <= sx_in;
         s1_sy_ff   <= sy_in;
      end
   end

   // Clip against the window and linearise the address
   always_comb begin
      in_x = !s1_sx_ff[COORD_W-1]
             && (s1_sx_ff[COORD_W-2:0] < (COORD_W-1)'(eff_w));
      in_y = !s1_sy_ff[COORD_W-1]
             && (s1_sy_ff[COORD_W-2:0] < (COORD_W-1)'(eff_h));
      x    = s1_sx_ff[XW-1:0];
      y    = s1_sy_ff[YW-1:0];
      lin  = LW'(y) * LW'(eff_w) + LW'(x);

      ctl.hit  = in_x && in_y
                 && (s1_func_ff == FUNC_BLEND || s1_func_ff == FUNC_READ
                     || s1_func_ff == FUNC_CLEAR);
      ctl.func = func_type'(s1_func_ff);
      ctl.cov  = s1_cov_ff;
   end

   assign valid = s1_valid_ff;
   assign addr  = lin[AW-1:0];

endmodule
`default_nettype wire
